// ----- sv/ccirc_pkg.sv -----
// Shared constants for the circumcircle pipeline.
`default_nettype none
package ccirc_pkg;
    localparam int COORD_WIDTH = 32;
endpackage
`default_nettype wire

// ----- sv/ccirc_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with sideband.
`default_nettype none
module ccirc_div #(
    parameter int NW = 99,
    parameter int DW = 68,
    parameter int QB = 33,
    parameter int SW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_ce,
    input  wire logic          i_vld,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    input  wire logic [SW-1:0] i_side,
    output logic               o_vld,
    output logic [QB-1:0]      o_quo,
    output logic               o_big,
    output logic [SW-1:0]      o_side
);
    logic [NW-1:0] r_rem  [0:QB];
    logic [DW-1:0] r_d    [0:QB];
    logic [QB-1:0] r_q    [0:QB];
    logic [SW-1:0] r_side [0:QB];
    logic          r_big  [0:QB];
    logic [QB:0]   r_vld;

    // quotient would need more than QB bits
    logic w_big;
    assign w_big = (i_num >> QB) >= NW'(i_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_ce) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_rem[0]  <= i_num;
            r_d[0]    <= i_den;
            r_q[0]    <= '0;
            r_side[0] <= i_side;
            r_big[0]  <= w_big;
        end
    end

    for (genvar s = 1; s <= QB; s++) begin : g_stage
        localparam int K = QB - s;
        logic          w_ge;
        logic [NW-1:0] n_rem;
        assign w_ge  = (r_rem[s-1] >> K) >= NW'(r_d[s-1]);
        assign n_rem = w_ge ? r_rem[s-1] - (NW'(r_d[s-1]) << K) : r_rem[s-1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_ce) begin
                r_vld[s] <= r_vld[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[s]  <= n_rem;
                r_d[s]    <= r_d[s-1];
                r_q[s]    <= r_q[s-1] | (QB'(w_ge) << K);
                r_side[s] <= r_side[s-1];
                r_big[s]  <= r_big[s-1];
            end
        end
    end

    assign o_vld  = r_vld[QB];
    assign o_quo  = r_q[QB];
    assign o_big  = r_big[QB];
    assign o_side = r_side[QB];
endmodule
`default_nettype wire

// ----- sv/ccirc_sqrt.sv -----
// Pipelined integer square root, one root bit per stage, with sideband.
`default_nettype none
module ccirc_sqrt #(
    parameter int RB = 31,
    parameter int SW = 1
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_ce,
    input  wire logic            i_vld,
    input  wire logic [2*RB-1:0] i_val,
    input  wire logic [SW-1:0]   i_side,
    output logic                 o_vld,
    output logic [RB-1:0]        o_root,
    output logic [SW-1:0]        o_side
);
    localparam int EW = 2 * RB + 1;

    logic [EW-1:0] r_e    [0:RB];
    logic [RB-1:0] r_root [0:RB];
    logic [SW-1:0] r_side [0:RB];
    logic [RB:0]   r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_ce) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_e[0]    <= EW'(i_val);
            r_root[0] <= '0;
            r_side[0] <= i_side;
        end
    end

    for (genvar s = 1; s <= RB; s++) begin : g_stage
        localparam int K = RB - s;
        // (root + 2^K)^2 - root^2
        logic [EW-1:0] w_trial;
        logic          w_ge;
        assign w_trial = (EW'(r_root[s-1]) << (K + 1)) + (EW'(1) << (2 * K));
        assign w_ge    = r_e[s-1] >= w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_ce) begin
                r_vld[s] <= r_vld[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_e[s]    <= w_ge ? r_e[s-1] - w_trial : r_e[s-1];
                r_root[s] <= r_root[s-1] | (RB'(w_ge) << K);
                r_side[s] <= r_side[s-1];
            end
        end
    end

    assign o_vld  = r_vld[RB];
    assign o_root = r_root[RB];
    assign o_side = r_side[RB];
endmodule
`default_nettype wire

// ----- sv/circumcircle_from_three_points.sv -----
// Throughput is one item per cycle while the output is not stalled.
// Depth is set by the two bit-serial dividers (COORD_WIDTH+2 stages) and the
// root unit (COORD_WIDTH stages); the whole pipeline holds while a result waits.
// Reset (synchronous, active low) clears all valid bits; data registers keep state.
`default_nettype none
module circumcircle_from_three_points #(
    parameter int COORD_WIDTH = ccirc_pkg::COORD_WIDTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    // ax, ay, bx, by, cx, cy
    input  wire logic [6*COORD_WIDTH-1:0] i_s_tdata,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    // center_x, center_y, radius, zero pad
    output logic [((3*COORD_WIDTH-1+7)/8)*8-1:0] o_m_tdata,
    // degenerate, overflow
    output logic [1:0]                 o_m_tuser
);
    localparam int W   = COORD_WIDTH;
    localparam int PW  = 2 * W + 2;
    localparam int DEN = 2 * W + 4;
    localparam int NWS = 3 * W + 3;
    localparam int QB  = W + 1;
    localparam int OW  = ((3 * W - 1 + 7) / 8) * 8;

    logic w_ce;
    logic r_out_vld;
    assign w_ce       = i_m_tready | ~r_out_vld;
    assign o_s_tready = w_ce;

    logic [5:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_ce) begin
            r_vld <= {r_vld[4:0], i_s_tvalid};
        end
    end

    // stage 1: coordinates and differences
    logic signed [W-1:0] w_ax, w_ay, w_bx, w_by, w_cx, w_cy;
    assign w_ax = i_s_tdata[0*W +: W];
    assign w_ay = i_s_tdata[1*W +: W];
    assign w_bx = i_s_tdata[2*W +: W];
    assign w_by = i_s_tdata[3*W +: W];
    assign w_cx = i_s_tdata[4*W +: W];
    assign w_cy = i_s_tdata[5*W +: W];

    logic signed [W-1:0] r1_ax, r1_ay, r1_bx, r1_by, r1_cx, r1_cy;
    logic signed [W:0]   r1_dxb, r1_dyb, r1_dxc, r1_dyc;
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r1_ax  <= w_ax; r1_ay <= w_ay; r1_bx <= w_bx;
            r1_by  <= w_by; r1_cx <= w_cx; r1_cy <= w_cy;
            r1_dxb <= (W+1)'(w_bx) - (W+1)'(w_ax);
            r1_dyb <= (W+1)'(w_by) - (W+1)'(w_ay);
            r1_dxc <= (W+1)'(w_cx) - (W+1)'(w_ax);
            r1_dyc <= (W+1)'(w_cy) - (W+1)'(w_ay);
        end
    end

    // stage 2: squares and cross products
    logic signed [2*W-1:0] r2_sax, r2_say, r2_sbx, r2_sby, r2_scx, r2_scy;
    logic signed [PW-1:0]  r2_pcb, r2_pbc;
    logic signed [W:0]     r2_dxb, r2_dyb, r2_dxc, r2_dyc;
    logic signed [W-1:0]   r2_ax, r2_ay;
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r2_sax <= r1_ax * r1_ax; r2_say <= r1_ay * r1_ay;
            r2_sbx <= r1_bx * r1_bx; r2_sby <= r1_by * r1_by;
            r2_scx <= r1_cx * r1_cx; r2_scy <= r1_cy * r1_cy;
            r2_pcb <= r1_dxc * r1_dyb;
            r2_pbc <= r1_dxb * r1_dyc;
            r2_dxb <= r1_dxb; r2_dyb <= r1_dyb; r2_dxc <= r1_dxc; r2_dyc <= r1_dyc;
            r2_ax  <= r1_ax; r2_ay <= r1_ay;
        end
    end

    // stage 3: S2, S3 and denominator
    logic signed [PW-1:0]  r3_s2, r3_s3;
    logic signed [DEN-1:0] r3_den;
    logic signed [W:0]     r3_dxb, r3_dyb, r3_dxc, r3_dyc;
    logic signed [W-1:0]   r3_ax, r3_ay;
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r3_s2  <= PW'(r2_sbx) + PW'(r2_sby) - PW'(r2_sax) - PW'(r2_say);
            r3_s3  <= PW'(r2_scx) + PW'(r2_scy) - PW'(r2_sax) - PW'(r2_say);
            r3_den <= (DEN'(r2_pcb) - DEN'(r2_pbc)) <<< 1;
            r3_dxb <= r2_dxb; r3_dyb <= r2_dyb; r3_dxc <= r2_dxc; r3_dyc <= r2_dyc;
            r3_ax  <= r2_ax; r3_ay <= r2_ay;
        end
    end

    // stage 4: numerator partial products, S split into high and low halves
    logic signed [W+1:0] w_s2lo, w_s3lo;
    logic signed [W:0]   w_s2hi, w_s3hi;
    assign w_s2lo = {1'b0, r3_s2[W:0]};
    assign w_s3lo = {1'b0, r3_s3[W:0]};
    assign w_s2hi = r3_s2[PW-1:W+1];
    assign w_s3hi = r3_s3[PW-1:W+1];

    logic signed [2*W+2:0] r4_yl3, r4_yl2, r4_xl3, r4_xl2;
    logic signed [2*W+1:0] r4_yh3, r4_yh2, r4_xh3, r4_xh2;
    logic signed [DEN-1:0] r4_den;
    logic signed [W-1:0]   r4_ax, r4_ay;
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r4_yl3 <= r3_dyb * w_s3lo; r4_yh3 <= r3_dyb * w_s3hi;
            r4_yl2 <= r3_dyc * w_s2lo; r4_yh2 <= r3_dyc * w_s2hi;
            r4_xl3 <= r3_dxb * w_s3lo; r4_xh3 <= r3_dxb * w_s3hi;
            r4_xl2 <= r3_dxc * w_s2lo; r4_xh2 <= r3_dxc * w_s2hi;
            r4_den <= r3_den; r4_ax <= r3_ax; r4_ay <= r3_ay;
        end
    end

    // stage 5: numerators
    logic signed [NWS-1:0] r5_nx, r5_ny;
    logic signed [DEN-1:0] r5_den;
    logic signed [W-1:0]   r5_ax, r5_ay;
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r5_nx  <= ((NWS'(r4_yh3) - NWS'(r4_yh2)) <<< (W + 1))
                      + NWS'(r4_yl3) - NWS'(r4_yl2);
            r5_ny  <= ((NWS'(r4_xh3) - NWS'(r4_xh2)) <<< (W + 1))
                      + NWS'(r4_xl3) - NWS'(r4_xl2);
            r5_den <= r4_den; r5_ax <= r4_ax; r5_ay <= r4_ay;
        end
    end

    // stage 6: magnitudes and quotient signs; y divides by -D
    logic [NWS-1:0]      r6_anx, r6_any;
    logic [DEN-1:0]      r6_ad;
    logic                r6_negx, r6_negy, r6_degen;
    logic signed [W-1:0] r6_ax, r6_ay;
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r6_anx   <= r5_nx[NWS-1] ? NWS'(-r5_nx) : NWS'(r5_nx);
            r6_any   <= r5_ny[NWS-1] ? NWS'(-r5_ny) : NWS'(r5_ny);
            r6_ad    <= r5_den[DEN-1] ? DEN'(-r5_den) : DEN'(r5_den);
            r6_negx  <= r5_nx[NWS-1] ^ r5_den[DEN-1];
            r6_negy  <= r5_ny[NWS-1] ^ ~r5_den[DEN-1];
            r6_degen <= (r5_den == '0);
            r6_ax    <= r5_ax; r6_ay <= r5_ay;
        end
    end

    logic          w_dx_vld, w_dy_vld, w_dx_big, w_dy_big;
    logic [QB-1:0] w_qx, w_qy;
    logic [W:0]    w_sidex_o;
    logic [W+1:0]  w_sidey_o;

    ccirc_div #(.NW(NWS), .DW(DEN), .QB(QB), .SW(W + 1)) u_div_x (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ce   (w_ce),
        .i_vld  (r_vld[5]),
        .i_num  (r6_anx),
        .i_den  (r6_ad),
        .i_side ({r6_negx, r6_ax}),
        .o_vld  (w_dx_vld),
        .o_quo  (w_qx),
        .o_big  (w_dx_big),
        .o_side (w_sidex_o)
    );

    ccirc_div #(.NW(NWS), .DW(DEN), .QB(QB), .SW(W + 2)) u_div_y (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ce   (w_ce),
        .i_vld  (r_vld[5]),
        .i_num  (r6_any),
        .i_den  (r6_ad),
        .i_side ({r6_degen, r6_negy, r6_ay}),
        .o_vld  (w_dy_vld),
        .o_quo  (w_qy),
        .o_big  (w_dy_big),
        .o_side (w_sidey_o)
    );

    // stage 7: signed, saturated centre
    localparam logic [QB-1:0] CHALF = QB'(1) << (W - 1);

    logic        w_negx, w_negy, w_satx, w_saty;
    logic [W-1:0] w_ox, w_oy;
    assign w_negx = w_sidex_o[W];
    assign w_negy = w_sidey_o[W];

    always_comb begin
        if (w_negx) begin
            w_satx = w_dx_big | (w_qx > CHALF);
            w_ox   = w_satx ? W'(CHALF) : W'(-w_qx);
        end else begin
            w_satx = w_dx_big | (w_qx >= CHALF);
            w_ox   = w_satx ? W'(CHALF - QB'(1)) : W'(w_qx);
        end
        if (w_negy) begin
            w_saty = w_dy_big | (w_qy > CHALF);
            w_oy   = w_saty ? W'(CHALF) : W'(-w_qy);
        end else begin
            w_saty = w_dy_big | (w_qy >= CHALF);
            w_oy   = w_saty ? W'(CHALF - QB'(1)) : W'(w_qy);
        end
    end

    logic [3:0] r_tvld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvld <= '0;
        end else if (w_ce) begin
            r_tvld <= {r_tvld[2:0], w_dx_vld & w_dy_vld};
        end
    end

    logic signed [W-1:0] r7_ox, r7_oy, r7_ax, r7_ay;
    logic                r7_sat, r7_degen;
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r7_ox    <= w_ox;
            r7_oy    <= w_oy;
            r7_sat   <= w_satx | w_saty;
            r7_degen <= w_sidey_o[W+1];
            r7_ax    <= w_sidex_o[W-1:0];
            r7_ay    <= w_sidey_o[W-1:0];
        end
    end

    // stage 8: offsets from the first point
    logic signed [W:0]   r8_rx, r8_ry;
    logic signed [W-1:0] r8_ox, r8_oy;
    logic                r8_sat, r8_degen;
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r8_rx <= (W+1)'(r7_ox) - (W+1)'(r7_ax);
            r8_ry <= (W+1)'(r7_oy) - (W+1)'(r7_ay);
            r8_ox <= r7_ox; r8_oy <= r7_oy; r8_sat <= r7_sat; r8_degen <= r7_degen;
        end
    end

    // stage 9: squared offsets
    logic signed [PW-1:0] r9_qx, r9_qy;
    logic signed [W-1:0]  r9_ox, r9_oy;
    logic                 r9_sat, r9_degen;
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r9_qx <= r8_rx * r8_rx;
            r9_qy <= r8_ry * r8_ry;
            r9_ox <= r8_ox; r9_oy <= r8_oy; r9_sat <= r8_sat; r9_degen <= r8_degen;
        end
    end

    // stage 10: squared distance; root fits W-1 bits only below 2^(2W-2)
    logic [PW:0] w_sum;
    assign w_sum = (PW+1)'(unsigned'(r9_qx)) + (PW+1)'(unsigned'(r9_qy));

    logic [2*W-3:0]      r10_sum;
    logic signed [W-1:0] r10_ox, r10_oy;
    logic                r10_ov, r10_degen;
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r10_sum   <= w_sum[2*W-3:0];
            r10_ov    <= r9_sat | (w_sum[PW:2*W-2] != '0);
            r10_ox    <= r9_ox; r10_oy <= r9_oy; r10_degen <= r9_degen;
        end
    end

    logic           w_sq_vld;
    logic [W-2:0]   w_root;
    logic [2*W+1:0] w_sq_side;

    ccirc_sqrt #(.RB(W - 1), .SW(2 * W + 2)) u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ce   (w_ce),
        .i_vld  (r_tvld[3]),
        .i_val  (r10_sum),
        .i_side ({r10_degen, r10_ov, r10_oy, r10_ox}),
        .o_vld  (w_sq_vld),
        .o_root (w_root),
        .o_side (w_sq_side)
    );

    // output register
    logic [W-1:0] r_out_cx, r_out_cy;
    logic [W-2:0] r_out_rad;
    logic         r_out_degen, r_out_ov;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_ce) begin
            r_out_vld <= w_sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            if (w_sq_side[2*W+1]) begin
                r_out_cx    <= '0;
                r_out_cy    <= '0;
                r_out_rad   <= '0;
                r_out_degen <= 1'b1;
                r_out_ov    <= 1'b0;
            end else begin
                r_out_cx    <= w_sq_side[W-1:0];
                r_out_cy    <= w_sq_side[2*W-1:W];
                r_out_rad   <= w_sq_side[2*W] ? '1 : w_root;
                r_out_degen <= 1'b0;
                r_out_ov    <= w_sq_side[2*W];
            end
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = OW'({r_out_rad, r_out_cy, r_out_cx});
    assign o_m_tuser  = {r_out_ov, r_out_degen};
endmodule
`default_nettype wire

// ----- test/circle_checker.sv -----
// Checker for the circumcircle block: predicts each result and compares it.
`timescale 1ns / 1ps
module circle_checker (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    input  wire logic         i_s_tready,
    input  wire logic [191:0] i_s_tdata,   // ax, ay, bx, by, cx, cy
    input  wire logic         i_m_tvalid,
    input  wire logic         i_m_tready,
    input  wire logic [95:0]  i_m_tdata,   // center_x, center_y, radius, zero pad
    input  wire logic [1:0]   i_m_tuser,   // degenerate, overflow
    output int                o_errors,
    output int                o_pending,
    output int                o_results,
    output int                o_degenerate_seen,
    output int                o_overflow_seen
);
    typedef struct packed {
        logic [31:0] center_x;
        logic [31:0] center_y;
        logic [30:0] radius;
        logic        degenerate;
        logic        overflow;
    } t_circle;

    localparam logic signed [191:0] COORD_MAX = 192'sd2147483647;
    localparam logic signed [191:0] COORD_MIN = -192'sd2147483648;

    t_circle expected_circles[$];

    function automatic logic [191:0] isqrt(input logic [191:0] n);
        logic [191:0] root;
        logic [191:0] cand;
        root = '0;
        for (int i = 95; i >= 0; i--) begin
            cand = root | (192'd1 << i);
            if (cand * cand <= n) root = cand;
        end
        return root;
    endfunction

    function automatic t_circle predict_circle(input logic [191:0] pts);
        logic signed [191:0] ax, ay, bx, by, cx, cy;
        logic signed [191:0] dxb, dyb, dxc, dyc, a2, s2, s3, den, nx, ny, qx, qy, rx, ry;
        logic [191:0] root;
        t_circle r;
        ax = $signed(pts[31:0]);    ay = $signed(pts[63:32]);
        bx = $signed(pts[95:64]);   by = $signed(pts[127:96]);
        cx = $signed(pts[159:128]); cy = $signed(pts[191:160]);
        dxb = bx - ax; dyb = by - ay; dxc = cx - ax; dyc = cy - ay;
        a2 = ax * ax + ay * ay;
        s2 = bx * bx + by * by - a2;
        s3 = cx * cx + cy * cy - a2;
        den = 2 * (dxc * dyb) - 2 * (dxb * dyc);
        r = '0;
        if (den == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        nx = dyb * s3 - dyc * s2;
        ny = dxb * s3 - dxc * s2;
        qx = nx / den;
        qy = ny / (-den);
        if (qx > COORD_MAX) begin qx = COORD_MAX; r.overflow = 1'b1; end
        if (qx < COORD_MIN) begin qx = COORD_MIN; r.overflow = 1'b1; end
        if (qy > COORD_MAX) begin qy = COORD_MAX; r.overflow = 1'b1; end
        if (qy < COORD_MIN) begin qy = COORD_MIN; r.overflow = 1'b1; end
        r.center_x = qx[31:0];
        r.center_y = qy[31:0];
        if (r.overflow) begin
            r.radius = '1;
        end else begin
            rx = qx - ax;
            ry = qy - ay;
            root = isqrt(rx * rx + ry * ry);
            if (root > 192'd2147483647) begin
                r.radius = '1;
                r.overflow = 1'b1;
            end else begin
                r.radius = root[30:0];
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_circle want;
        t_circle got;
        int      errs;
        errs = 0;
        if (!i_rst_n) begin
            expected_circles.delete();
            o_errors <= 0;
            o_pending <= 0;
            o_results <= 0;
            o_degenerate_seen <= 0;
            o_overflow_seen <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready) expected_circles.push_back(predict_circle(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                got = {i_m_tdata[31:0], i_m_tdata[63:32], i_m_tdata[94:64],
                       i_m_tuser[0], i_m_tuser[1]};
                o_results <= o_results + 1;
                if (got.degenerate) o_degenerate_seen <= o_degenerate_seen + 1;
                if (got.overflow) o_overflow_seen <= o_overflow_seen + 1;
                if (i_m_tdata[95] !== 1'b0) begin
                    $display("%0t: pad bit expected 0, actual %b", $time, i_m_tdata[95]);
                    errs = errs + 1;
                end
                if (expected_circles.size() == 0) begin
                    $display("%0t: unexpected item, actual cx=%h cy=%h r=%h deg=%b ovf=%b",
                             $time, got.center_x, got.center_y, got.radius,
                             got.degenerate, got.overflow);
                    errs = errs + 1;
                end else begin
                    want = expected_circles.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected cx=%h cy=%h r=%h deg=%b ovf=%b",
                                 $time, want.center_x, want.center_y, want.radius,
                                 want.degenerate, want.overflow);
                        $display("%0t:          actual   cx=%h cy=%h r=%h deg=%b ovf=%b",
                                 $time, got.center_x, got.center_y, got.radius,
                                 got.degenerate, got.overflow);
                        errs = errs + 1;
                    end
                end
            end
            o_errors <= o_errors + errs;
            o_pending <= expected_circles.size();
        end
    end
endmodule

// ----- test/tb_circumcircle_from_three_points.sv -----
// Testbench top for the circumcircle block: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb_circumcircle_from_three_points;
    localparam int ONE = 65536;   // 1.0 in Q16.16
    localparam int RANDOM_ITEMS = 1000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [95:0]  m_tdata;
    logic [1:0]   m_tuser;
    logic         quiet = 1'b0;
    int           errors, pending, results, degen_seen, ovf_seen;

    always #10 i_clk = ~i_clk;

    circumcircle_from_three_points dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready), .i_s_tdata(s_tdata),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .o_m_tdata(m_tdata), .o_m_tuser(m_tuser)
    );

    circle_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .i_m_tuser(m_tuser),
        .o_errors(errors), .o_pending(pending), .o_results(results),
        .o_degenerate_seen(degen_seen), .o_overflow_seen(ovf_seen)
    );

    // Present one point triple and hold it until it is taken; ready only moves
    // at a rising edge, so its value at the falling edge is what the next edge sees.
    task automatic send_triangle(input int ax, ay, bx, by, cx, cy);
        bit taken;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {cy, cx, by, bx, ay, ax};
        taken = 0;
        while (!taken) begin
            @(negedge i_clk);
            taken = s_tready;
            @(posedge i_clk);
        end
    endtask

    function automatic int rand_coord(input int mode);
        case (mode)
            0: return $urandom();
            1: return $urandom_range(0, 2 * 64 * ONE) - 64 * ONE;
            default: return $urandom_range(0, 2 * 1024) - 1024;
        endcase
    endfunction

    // Result side: bursts of stall, none in the quiet tail.
    initial begin
        @(posedge i_clk);
        forever begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
            if (!quiet) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int ax, ay, dx, dy, k, mode;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: degenerate cases, plain triangles, extremes
        send_triangle(0, 0, 0, 0, 0, 0);
        send_triangle(ONE, ONE, ONE, ONE, 5 * ONE, -3 * ONE);
        send_triangle(0, 0, ONE, ONE, 2 * ONE, 2 * ONE);
        send_triangle(0, 0, 2 * ONE, 0, 0, 2 * ONE);
        send_triangle(-3 * ONE, 0, 3 * ONE, 0, 0, 3 * ONE);
        send_triangle(ONE, 2 * ONE, -5 * ONE, 7 * ONE, 4 * ONE, -ONE);
        send_triangle(0, 0, 1, 0, 0, 1);
        send_triangle(0, 0, 100 * ONE, 0, 50 * ONE, 1);
        send_triangle(0, 0, 1000 * ONE, 0, 500 * ONE, -1);
        send_triangle(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                      32'h7fffffff, 32'h80000000);
        send_triangle(32'h80000000, 0, 32'h7fffffff, 0, 0, 32'h7fffffff);
        send_triangle(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                      32'h7fffffff, 32'h7fffffff);
        send_triangle(32'hffffffff, 32'hffffffff, 0, 32'hffffffff, 32'hffffffff, 0);
        send_triangle(32'h7fff0000, 0, 0, 32'h7fff0000, 32'h80010000, 0);
        send_triangle(-20000 * ONE, 0, 20000 * ONE, 0, 0, 20000 * ONE);
        send_triangle(30000 * ONE, 30000 * ONE, -30000 * ONE, 30000 * ONE,
                      0, -30000 * ONE);
        send_triangle(32'h55555555, 32'haaaaaaaa, 32'haaaaaaaa, 32'h55555555,
                      32'h12345678, 32'hedcba987);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n > RANDOM_ITEMS * 9 / 10) quiet = 1'b1;
            mode = $urandom_range(0, 2);
            case ($urandom_range(0, 9))
                0, 1: begin
                    // collinear: C lies on the line through A and B
                    ax = rand_coord(2); ay = rand_coord(2);
                    dx = rand_coord(2); dy = rand_coord(2);
                    k = $urandom_range(0, 6) - 3;
                    send_triangle(ax * 64, ay * 64, (ax + dx) * 64, (ay + dy) * 64,
                                  (ax + k * dx) * 64, (ay + k * dy) * 64);
                end
                2: begin
                    // almost collinear: centre lands far away
                    ax = rand_coord(2); ay = rand_coord(2);
                    dx = rand_coord(2); dy = rand_coord(2);
                    send_triangle(ax * ONE, ay * ONE, (ax + dx) * ONE, (ay + dy) * ONE,
                                  (ax + 2 * dx) * ONE + $urandom_range(1, 3),
                                  (ay + 2 * dy) * ONE);
                end
                default:
                    send_triangle(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                                  rand_coord(mode), rand_coord(mode), rand_coord(mode));
            endcase
        end
        s_tvalid <= 1'b0;
        @(posedge i_clk);

        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("Covered %0d results: %0d collinear, %0d saturated, rest plain circles,",
                 results, degen_seen, ovf_seen);
        $display("with random stalls on both sides and a stall-free tail.");
        if (errors == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
